### src/mkuf_pkg.sv
// Package for the MAC-keyed uplink filter.
// Holds slot-table sizing, command and register codes, and shared structs.
// No dependencies.
`default_nettype none

package mkuf_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CFG_IDX_W  = 2;

  localparam logic [2:0] CMD_UPLINK    = 3'd0;
  localparam logic [2:0] CMD_DOWNLINK  = 3'd1;
  localparam logic [2:0] CMD_SET_ID    = 3'd2;
  localparam logic [2:0] CMD_REMOVE    = 3'd3;
  localparam logic [2:0] CMD_SET_BLOCK = 3'd4;
  localparam logic [2:0] CMD_READ      = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ALLOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AP_ADDRESS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AP_NETMASK    = 2'd2;

  localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
  localparam logic [15:0] MIN_UPLINK_LEN   = 16'd34;
  localparam logic [15:0] MIN_DOWNLINK_LEN = 16'd14;
  localparam logic [31:0] BCAST_IP         = 32'hFFFF_FFFF;
  localparam logic [3:0]  MCAST_PREFIX     = 4'hE;
  localparam int          MAC_GROUP_BIT    = 40;

  typedef struct packed {
    logic [2:0]  command;
    logic [47:0] mac_addr;
    logic [15:0] ether_type;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] first_seg_len;
    logic [15:0] total_len;
    logic [31:0] now_ms;
    logic [3:0]  slot;
    logic        block_flag;
  } req_t;

  typedef struct packed {
    logic        forward;
    logic        hit;
    logic [3:0]  hit_slot;
    logic [31:0] client_ip;
    logic [31:0] up_bytes;
    logic [31:0] down_bytes;
    logic [31:0] last_active_ms;
    logic        slot_blocked;
  } rsp_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [31:0] up;
    logic [31:0] down;
    logic [31:0] last;
  } slot_data_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] idx;
    logic              mac_we;
    logic [47:0]       mac;
    logic              valid;
    logic              block;
  } cam_wr_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] idx;
    logic              valid;
    logic              block;
  } cam_rd_t;

endpackage

`default_nettype wire

### src/mkuf_ifs.sv
// Channel interfaces for the MAC-keyed uplink filter: request, response, config.
// Depends on mkuf_pkg.
`default_nettype none

interface mkuf_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [47:0] mac_addr;
  logic [15:0] ether_type;
  logic [31:0] source_ip;
  logic [31:0] dest_ip;
  logic [15:0] first_seg_len;
  logic [15:0] total_len;
  logic [31:0] now_ms;
  logic [3:0]  slot;
  logic        block_flag;

  modport source (output valid, command, mac_addr, ether_type, source_ip, dest_ip,
                  first_seg_len, total_len, now_ms, slot, block_flag, input ready);
  modport sink   (input valid, command, mac_addr, ether_type, source_ip, dest_ip,
                  first_seg_len, total_len, now_ms, slot, block_flag, output ready);
endinterface

interface mkuf_rsp_if;
  logic        valid;
  logic        ready;
  logic        forward;
  logic        hit;
  logic [3:0]  hit_slot;
  logic [31:0] client_ip;
  logic [31:0] up_bytes;
  logic [31:0] down_bytes;
  logic [31:0] last_active_ms;
  logic        slot_blocked;

  modport source (output valid, forward, hit, hit_slot, client_ip, up_bytes, down_bytes,
                  last_active_ms, slot_blocked, input ready);
  modport sink   (input valid, forward, hit, hit_slot, client_ip, up_bytes, down_bytes,
                  last_active_ms, slot_blocked, output ready);
endinterface

interface mkuf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mkuf_pkg::CFG_IDX_W-1:0]   index;
  logic [31:0]                      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/mkuf_cam.sv
// MAC match array for the uplink filter: per-slot MAC, valid and blocked bits.
// Depends on mkuf_pkg.
`default_nettype none

module mkuf_cam (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [47:0]                look_mac_i,
  input  logic [mkuf_pkg::SLOT_W-1:0] rd_idx_i,
  input  mkuf_pkg::cam_wr_t          wr_i,
  output mkuf_pkg::cam_rd_t          rd_o
);
  import mkuf_pkg::*;

  logic [47:0]           mac_q   [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid_q;
  logic [SLOT_COUNT-1:0] block_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      block_q <= '0;
    end else if (wr_i.we) begin
      valid_q[wr_i.idx] <= wr_i.valid;
      block_q[wr_i.idx] <= wr_i.block;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we && wr_i.mac_we) begin
      mac_q[wr_i.idx] <= wr_i.mac;
    end
  end

  // lowest valid slot wins
  always_comb begin
    rd_o.hit   = 1'b0;
    rd_o.idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (valid_q[i] && (mac_q[i] == look_mac_i)) begin
        rd_o.hit = 1'b1;
        rd_o.idx = SLOT_W'(i);
      end
    end
    rd_o.valid = valid_q[rd_idx_i];
    rd_o.block = block_q[rd_idx_i];
  end

endmodule

`default_nettype wire

### src/mac_keyed_uplink_filter.sv
// Top level of the MAC-keyed uplink filter with per-slot byte accounting.
// Depends on mkuf_pkg, mkuf_ifs and mkuf_cam.
//
// Each request passes through a lookup cycle, in which the MAC match array
// picks the slot and the slot memory (IP, byte counts, time stamp; one
// read/write port, registered read) is read, and an update cycle, in
// which the slot is written back and the result is registered. A new request
// is accepted during the update cycle, so back-to-back requests overlap with
// the previous update; a result that is not taken holds the update cycle. The
// slot table is empty after reset without a clearing pass.
`default_nettype none

module mac_keyed_uplink_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  mkuf_req_if.sink    req_i,
  mkuf_rsp_if.source  rsp_o,
  mkuf_cfg_if.sink    cfg_i
);
  import mkuf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPD
  } state_e;

  state_e            state_q;
  req_t              req_q;
  logic [SLOT_W-1:0] idx_q;
  logic              hit_q;
  logic              rsp_valid_q;
  rsp_t              rsp_q;

  logic        allow_q;
  logic [31:0] ap_addr_q;
  logic [31:0] ap_mask_q;

  slot_data_t            mem_q [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] data_ok_q;
  slot_data_t            rdata_q;
  logic                  rd_ok_q;

  req_t              req_in;
  logic              req_fire;
  logic              out_free;
  logic              upd_fire;
  logic              slot_cmd;
  logic [SLOT_W-1:0] look_idx;
  cam_wr_t           cam_wr;
  cam_rd_t           cam_rd;
  slot_data_t        cur;
  slot_data_t        nxt;
  logic              new_valid;
  logic              new_block;
  logic              fwd;
  logic              report;
  logic              mem_we;
  logic              exam_up;
  logic              exam_dn;
  logic              slot_ok;
  logic              dest_local;
  rsp_t              rsp_d;

  assign req_in = '{command: req_i.command, mac_addr: req_i.mac_addr,
                    ether_type: req_i.ether_type, source_ip: req_i.source_ip,
                    dest_ip: req_i.dest_ip, first_seg_len: req_i.first_seg_len,
                    total_len: req_i.total_len, now_ms: req_i.now_ms,
                    slot: req_i.slot, block_flag: req_i.block_flag};

  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign upd_fire    = (state_q == ST_UPD) && out_free;
  assign req_i.ready = (state_q == ST_IDLE) || upd_fire;
  assign req_fire    = req_i.valid && req_i.ready;

  assign slot_cmd = (req_q.command inside {CMD_SET_ID, CMD_REMOVE, CMD_SET_BLOCK, CMD_READ});
  assign look_idx = slot_cmd ? SLOT_W'(req_q.slot) : cam_rd.idx;

  mkuf_cam u_cam (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .look_mac_i (req_q.mac_addr),
    .rd_idx_i   (idx_q),
    .wr_i       (cam_wr),
    .rd_o       (cam_rd)
  );

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_q   <= 1'b1;
      ap_addr_q <= '0;
      ap_mask_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_DEFAULT_ALLOW: allow_q   <= cfg_i.data[0];
        REG_AP_ADDRESS:    ap_addr_q <= cfg_i.data;
        REG_AP_NETMASK:    ap_mask_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // slot memory
  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOOK) begin
      rdata_q <= mem_q[look_idx];
    end
    if (mem_we) begin
      mem_q[idx_q] <= nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_ok_q <= '0;
      rd_ok_q   <= 1'b0;
    end else begin
      if (state_q == ST_LOOK) begin
        rd_ok_q <= data_ok_q[look_idx];
      end
      if (mem_we) begin
        data_ok_q[idx_q] <= 1'b1;
      end
    end
  end

  // update
  assign cur        = rd_ok_q ? rdata_q : '0;
  assign exam_up    = (req_q.first_seg_len >= MIN_UPLINK_LEN) &&
                      (req_q.ether_type == ETHERTYPE_IPV4);
  assign exam_dn    = (req_q.first_seg_len >= MIN_DOWNLINK_LEN) &&
                      !req_q.mac_addr[MAC_GROUP_BIT];
  assign slot_ok    = ({28'd0, req_q.slot} < 32'(SLOT_COUNT));
  assign dest_local = (req_q.dest_ip == BCAST_IP) ||
                      (req_q.dest_ip[31:28] == MCAST_PREFIX) ||
                      (ap_mask_q == '0) ||
                      ((req_q.dest_ip & ap_mask_q) == (ap_addr_q & ap_mask_q));

  always_comb begin
    nxt       = cur;
    new_valid = cam_rd.valid;
    new_block = cam_rd.block;
    fwd       = 1'b1;
    report    = 1'b0;
    mem_we    = 1'b0;
    cam_wr    = '{we: 1'b0, idx: idx_q, mac_we: 1'b0, mac: req_q.mac_addr,
                  valid: cam_rd.valid, block: cam_rd.block};
    case (req_q.command)
      CMD_UPLINK: begin
        if (exam_up) begin
          if (hit_q) begin
            report = 1'b1;
            mem_we = 1'b1;
            if (req_q.source_ip != '0) begin
              nxt.ip = req_q.source_ip;
            end
            if (!dest_local) begin
              if (cam_rd.block) begin
                fwd = 1'b0;
              end else begin
                nxt.up   = cur.up + 32'(req_q.total_len);
                nxt.last = req_q.now_ms;
              end
            end
          end else if (!dest_local && !allow_q) begin
            fwd = 1'b0;
          end
        end
      end
      CMD_DOWNLINK: begin
        if (exam_dn && hit_q) begin
          report   = 1'b1;
          mem_we   = 1'b1;
          nxt.down = cur.down + 32'(req_q.total_len);
        end
      end
      CMD_SET_ID: begin
        if (slot_ok) begin
          report        = 1'b1;
          mem_we        = 1'b1;
          nxt           = '0;
          new_valid     = 1'b1;
          new_block     = 1'b1;
          cam_wr.we     = 1'b1;
          cam_wr.mac_we = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (slot_ok) begin
          report    = 1'b1;
          mem_we    = 1'b1;
          nxt       = '0;
          new_valid = 1'b0;
          new_block = 1'b0;
          cam_wr.we = 1'b1;
        end
      end
      CMD_SET_BLOCK: begin
        if (slot_ok) begin
          report    = 1'b1;
          new_block = req_q.block_flag;
          cam_wr.we = 1'b1;
        end
      end
      CMD_READ: begin
        report = slot_ok;
      end
      default: ;
    endcase
    cam_wr.valid = new_valid;
    cam_wr.block = new_block;
    cam_wr.we    = cam_wr.we && upd_fire;
    mem_we       = mem_we && upd_fire;

    rsp_d = '0;
    rsp_d.forward = fwd;
    if (slot_cmd) begin
      rsp_d.hit_slot = req_q.slot;
    end else if (report) begin
      rsp_d.hit_slot = 4'(idx_q);
    end
    if (report) begin
      rsp_d.hit            = new_valid;
      rsp_d.client_ip      = nxt.ip;
      rsp_d.up_bytes       = nxt.up;
      rsp_d.down_bytes     = nxt.down;
      rsp_d.last_active_ms = nxt.last;
      rsp_d.slot_blocked   = new_block;
    end
  end

  // sequencing and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      req_q       <= '0;
      idx_q       <= '0;
      hit_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      if (upd_fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (req_fire) begin
            req_q   <= req_in;
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          idx_q   <= look_idx;
          hit_q   <= cam_rd.hit;
          state_q <= ST_UPD;
        end
        ST_UPD: begin
          if (upd_fire) begin
            rsp_q <= rsp_d;
            if (req_fire) begin
              req_q   <= req_in;
              state_q <= ST_LOOK;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.forward        = rsp_q.forward;
  assign rsp_o.hit            = rsp_q.hit;
  assign rsp_o.hit_slot       = rsp_q.hit_slot;
  assign rsp_o.client_ip      = rsp_q.client_ip;
  assign rsp_o.up_bytes       = rsp_q.up_bytes;
  assign rsp_o.down_bytes     = rsp_q.down_bytes;
  assign rsp_o.last_active_ms = rsp_q.last_active_ms;
  assign rsp_o.slot_blocked   = rsp_q.slot_blocked;

endmodule

`default_nettype wire

### bench/mac_keyed_uplink_filter_tb.sv
// Self-checking bench for mac_keyed_uplink_filter: per-slot MAC matching, drop decisions
// and byte accounting are predicted in-bench and every transaction is compared field by field.
// Depends on mkuf_pkg, mkuf_ifs and the filter RTL.
`timescale 1ns / 100ps

module mac_keyed_uplink_filter_tb;
  import mkuf_pkg::*;

  localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED_7 = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PER_PHASE = 170;

  logic clk_i;
  logic rst_ni;

  mkuf_req_if req_if ();
  mkuf_rsp_if rsp_if ();
  mkuf_cfg_if cfg_if ();

  mac_keyed_uplink_filter DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  logic [47:0] tbl_mac   [SLOT_COUNT] = '{default: '0};
  logic        tbl_valid [SLOT_COUNT] = '{default: '0};
  logic        tbl_block [SLOT_COUNT] = '{default: '0};
  logic [31:0] tbl_ip    [SLOT_COUNT] = '{default: '0};
  logic [31:0] tbl_up    [SLOT_COUNT] = '{default: '0};
  logic [31:0] tbl_down  [SLOT_COUNT] = '{default: '0};
  logic [31:0] tbl_last  [SLOT_COUNT] = '{default: '0};

  logic        allow_unknown_cfg = 1'b1;
  logic [31:0] ap_addr_cfg = '0;
  logic [31:0] ap_mask_cfg = '0;

  logic [47:0] mac_pool [8] = '{
    48'h021A_2B3C_4D5E, 48'h02AA_BBCC_DD01, 48'h0200_0000_0002, 48'hACDE_4800_1234,
    48'h0100_5E00_00FB, 48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF, 48'hFEFF_FFFF_FFFE
  };

  req_t pending_frames [$];
  rsp_t predicted_verdicts [$];
  req_t in_flight_req;
  rsp_t produced_verdict;
  rsp_t want_rsp;
  int   outstanding = 0;
  int   mismatch_count = 0;
  int   send_hold = 0;
  int   recv_hold = 0;
  int   cycle_count = 0;
  logic quiet_tail = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int match_slot(input logic [47:0] mac);
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (tbl_valid[i] && tbl_mac[i] == mac) return i;
    end
    return -1;
  endfunction

  function automatic logic is_local_dest(input logic [31:0] dst);
    if (dst == BCAST_IP) return 1'b1;
    if (dst[31:28] == MCAST_PREFIX) return 1'b1;
    if (ap_mask_cfg == '0) return 1'b1;
    return (dst & ap_mask_cfg) == (ap_addr_cfg & ap_mask_cfg);
  endfunction

  task automatic report_slot(input int idx, inout rsp_t o);
    o.hit            = tbl_valid[idx];
    o.hit_slot       = 4'(idx);
    o.client_ip      = tbl_ip[idx];
    o.up_bytes       = tbl_up[idx];
    o.down_bytes     = tbl_down[idx];
    o.last_active_ms = tbl_last[idx];
    o.slot_blocked   = tbl_block[idx];
  endtask

  task automatic wipe_counters(input int idx);
    tbl_ip[idx]   = '0;
    tbl_up[idx]   = '0;
    tbl_down[idx] = '0;
    tbl_last[idx] = '0;
  endtask

  task automatic filter_predict(input req_t r, output rsp_t o);
    int idx;
    o = '0;
    o.forward = 1'b1;
    case (r.command)
      CMD_UPLINK: begin
        if (r.first_seg_len >= MIN_UPLINK_LEN && r.ether_type == ETHERTYPE_IPV4) begin
          idx = match_slot(r.mac_addr);
          if (idx >= 0 && r.source_ip != '0) tbl_ip[idx] = r.source_ip;
          if (!is_local_dest(r.dest_ip)) begin
            if (idx < 0) begin
              if (!allow_unknown_cfg) o.forward = 1'b0;
            end else if (tbl_block[idx]) begin
              o.forward = 1'b0;
            end else begin
              tbl_last[idx] = r.now_ms;
              tbl_up[idx]   = tbl_up[idx] + r.total_len;
            end
          end
          if (idx >= 0) report_slot(idx, o);
        end
      end
      CMD_DOWNLINK: begin
        if (r.first_seg_len >= MIN_DOWNLINK_LEN && !r.mac_addr[MAC_GROUP_BIT]) begin
          idx = match_slot(r.mac_addr);
          if (idx >= 0) begin
            tbl_down[idx] = tbl_down[idx] + r.total_len;
            report_slot(idx, o);
          end
        end
      end
      CMD_SET_ID, CMD_REMOVE, CMD_SET_BLOCK, CMD_READ: begin
        o.hit_slot = r.slot;
        if (r.slot < SLOT_COUNT) begin
          idx = int'(r.slot);
          if (r.command == CMD_SET_ID) begin
            tbl_mac[idx]   = r.mac_addr;
            tbl_block[idx] = 1'b1;
            tbl_valid[idx] = 1'b1;
            wipe_counters(idx);
          end else if (r.command == CMD_REMOVE) begin
            tbl_valid[idx] = 1'b0;
            tbl_block[idx] = 1'b0;
            wipe_counters(idx);
          end else if (r.command == CMD_SET_BLOCK) begin
            tbl_block[idx] = r.block_flag;
          end
          report_slot(idx, o);
        end
      end
      default: begin
      end
    endcase
  endtask

  function automatic req_t frame_up(input logic [47:0] mac, input logic [31:0] src,
                                    input logic [31:0] dst, input logic [15:0] seg,
                                    input logic [15:0] tot, input logic [31:0] now);
    req_t r;
    r = '0;
    r.command       = CMD_UPLINK;
    r.mac_addr      = mac;
    r.ether_type    = ETHERTYPE_IPV4;
    r.source_ip     = src;
    r.dest_ip       = dst;
    r.first_seg_len = seg;
    r.total_len     = tot;
    r.now_ms        = now;
    return r;
  endfunction

  function automatic req_t frame_down(input logic [47:0] mac, input logic [15:0] seg,
                                      input logic [15:0] tot);
    req_t r;
    r = '0;
    r.command       = CMD_DOWNLINK;
    r.mac_addr      = mac;
    r.first_seg_len = seg;
    r.total_len     = tot;
    return r;
  endfunction

  function automatic req_t slot_cmd(input logic [2:0] cmd, input logic [3:0] slot,
                                    input logic [47:0] mac, input logic flag);
    req_t r;
    r = '0;
    r.command    = cmd;
    r.slot       = slot;
    r.mac_addr   = mac;
    r.block_flag = flag;
    return r;
  endfunction

  function automatic logic [47:0] pick_mac();
    if ($urandom_range(0, 4) == 0) return {16'($urandom), 32'($urandom)};
    return mac_pool[$urandom_range(0, 7)];
  endfunction

  function automatic logic [31:0] pick_dest();
    logic [31:0] d;
    logic [31:0] inside_net;
    d = $urandom;
    inside_net = (ap_addr_cfg & ap_mask_cfg) | (d & ~ap_mask_cfg);
    case ($urandom_range(0, 9))
      0: d = BCAST_IP;
      1: d = {MCAST_PREFIX, d[27:0]};
      2, 3, 4: d = inside_net;
      5, 6, 7: d = inside_net ^ ap_mask_cfg;
      default: begin
      end
    endcase
    return d;
  endfunction

  function automatic req_t rand_request();
    req_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    r = '0;
    r.mac_addr      = pick_mac();
    r.source_ip     = ($urandom_range(0, 4) == 0) ? 32'h0 : 32'($urandom);
    r.dest_ip       = pick_dest();
    r.ether_type    = ETHERTYPE_IPV4;
    r.first_seg_len = 16'($urandom_range(34, 1518));
    r.total_len     = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1518));
    r.now_ms        = $urandom;
    r.slot          = 4'($urandom_range(0, SLOT_COUNT - 1));
    r.block_flag    = 1'($urandom_range(0, 1));
    if (pick < 34) begin
      r.command = CMD_UPLINK;
    end else if (pick < 42) begin
      r.command = CMD_UPLINK;
      case ($urandom_range(0, 2))
        0: r.ether_type = 16'($urandom);
        1: r.first_seg_len = 16'($urandom_range(0, 40));
        default: r.first_seg_len = 16'($urandom);
      endcase
    end else if (pick < 58) begin
      r.command = CMD_DOWNLINK;
      if ($urandom_range(0, 4) == 0) r.first_seg_len = 16'($urandom_range(0, 20));
      else r.first_seg_len = 16'($urandom_range(14, 1518));
    end else if (pick < 68) begin
      r.command = CMD_SET_ID;
    end else if (pick < 73) begin
      r.command = CMD_REMOVE;
    end else if (pick < 85) begin
      r.command = CMD_SET_BLOCK;
      r.block_flag = ($urandom_range(0, 9) < 3);
    end else if (pick < 97) begin
      r.command = CMD_READ;
    end else begin
      r.command = ($urandom_range(0, 1) == 0) ? CMD_UNUSED_6 : CMD_UNUSED_7;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk_i); while (pending_frames.size() != 0 || outstanding != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_DEFAULT_ALLOW: allow_unknown_cfg = val[0];
      REG_AP_ADDRESS:    ap_addr_cfg = val;
      REG_AP_NETMASK:    ap_mask_cfg = val;
      default: begin
      end
    endcase
  endtask

  task automatic program_regs(input logic allow, input logic [31:0] addr,
                              input logic [31:0] mask);
    wait_idle();
    write_reg(REG_DEFAULT_ALLOW, {31'b0, allow});
    write_reg(REG_AP_ADDRESS, addr);
    write_reg(REG_AP_NETMASK, mask);
    @(negedge clk_i);
  endtask

  task automatic queue_random(input int count);
    repeat (count) pending_frames.push_back(rand_request());
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      send_hold    <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        filter_predict(in_flight_req, produced_verdict);
        predicted_verdicts.push_back(produced_verdict);
      end
      if (!req_if.valid || req_if.ready) begin
        if (send_hold != 0) begin
          send_hold    <= send_hold - 1;
          req_if.valid <= 1'b0;
        end else if (pending_frames.size() != 0 && !quiet_tail && $urandom_range(0, 11) == 0) begin
          send_hold    <= $urandom_range(0, 17);
          req_if.valid <= 1'b0;
        end else if (pending_frames.size() != 0) begin
          in_flight_req = pending_frames.pop_front();
          outstanding++;
          req_if.valid         <= 1'b1;
          req_if.command       <= in_flight_req.command;
          req_if.mac_addr      <= in_flight_req.mac_addr;
          req_if.ether_type    <= in_flight_req.ether_type;
          req_if.source_ip     <= in_flight_req.source_ip;
          req_if.dest_ip       <= in_flight_req.dest_ip;
          req_if.first_seg_len <= in_flight_req.first_seg_len;
          req_if.total_len     <= in_flight_req.total_len;
          req_if.now_ms        <= in_flight_req.now_ms;
          req_if.slot          <= in_flight_req.slot;
          req_if.block_flag    <= in_flight_req.block_flag;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      recv_hold    <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (predicted_verdicts.size() == 0) begin
          $display("%0t: unexpected transaction: expected none, actual forward %b hit %b slot %0d",
                   $time, rsp_if.forward, rsp_if.hit, rsp_if.hit_slot);
          mismatch_count++;
        end else begin
          want_rsp = predicted_verdicts.pop_front();
          if (outstanding > 0) outstanding--;
          check_field("forward", 32'(want_rsp.forward), 32'(rsp_if.forward));
          check_field("hit", 32'(want_rsp.hit), 32'(rsp_if.hit));
          check_field("hit_slot", 32'(want_rsp.hit_slot), 32'(rsp_if.hit_slot));
          check_field("client_ip", want_rsp.client_ip, rsp_if.client_ip);
          check_field("up_bytes", want_rsp.up_bytes, rsp_if.up_bytes);
          check_field("down_bytes", want_rsp.down_bytes, rsp_if.down_bytes);
          check_field("last_active_ms", want_rsp.last_active_ms, rsp_if.last_active_ms);
          check_field("slot_blocked", 32'(want_rsp.slot_blocked), 32'(rsp_if.slot_blocked));
        end
      end
      if (recv_hold != 0) begin
        recv_hold    <= recv_hold - 1;
        rsp_if.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
        recv_hold    <= $urandom_range(0, 17);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    req_t r;
    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.command       = '0;
    req_if.mac_addr      = '0;
    req_if.ether_type    = '0;
    req_if.source_ip     = '0;
    req_if.dest_ip       = '0;
    req_if.first_seg_len = '0;
    req_if.total_len     = '0;
    req_if.now_ms        = '0;
    req_if.slot          = '0;
    req_if.block_flag    = 1'b0;
    rsp_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = '0;
    cfg_if.data          = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: subnet unknown, so every destination is local
    pending_frames.push_back(slot_cmd(CMD_READ, 4'd0, '0, 1'b0));
    pending_frames.push_back(frame_up(mac_pool[0], 32'hC0A8_0464, 32'h0808_0808, 16'd34,
                                      16'd100, 32'd1));
    pending_frames.push_back(slot_cmd(CMD_SET_ID, 4'd0, mac_pool[0], 1'b0));
    pending_frames.push_back(slot_cmd(CMD_SET_ID, 4'd15, 48'hFFFF_FFFF_FFFF, 1'b1));
    pending_frames.push_back(slot_cmd(CMD_SET_ID, 4'd3, mac_pool[0], 1'b0));
    pending_frames.push_back(frame_up(mac_pool[0], 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'hFFFF,
                                      32'hFFFF_FFFF));
    pending_frames.push_back(slot_cmd(CMD_SET_BLOCK, 4'd0, '0, 1'b0));
    pending_frames.push_back(frame_up(mac_pool[0], 32'h0, 32'h0A00_0001, 16'd34, 16'd60,
                                      32'd5));
    pending_frames.push_back(frame_down(mac_pool[0], 16'd14, 16'hFFFF));
    pending_frames.push_back(frame_down(mac_pool[0], 16'd13, 16'd500));
    pending_frames.push_back(frame_down(48'h0100_5E00_0001, 16'd64, 16'd100));
    pending_frames.push_back(frame_up(mac_pool[0], 32'h0A00_0009, 32'h0A00_0001, 16'd33,
                                      16'd60, 32'd6));
    r = frame_up(mac_pool[0], 32'h0A00_0009, 32'h0A00_0001, 16'd34, 16'd60, 32'd7);
    r.ether_type = 16'h86DD;
    pending_frames.push_back(r);
    pending_frames.push_back(slot_cmd(CMD_REMOVE, 4'd0, '0, 1'b0));
    pending_frames.push_back(frame_up(mac_pool[0], 32'h0A00_0002, 32'hE000_0001, 16'd60,
                                      16'd60, 32'd9));
    pending_frames.push_back(slot_cmd(CMD_SET_BLOCK, 4'd7, '0, 1'b1));
    pending_frames.push_back(slot_cmd(CMD_UNUSED_6, 4'd15, 48'hFFFF_FFFF_FFFF, 1'b1));
    pending_frames.push_back(frame_up(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                      16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));

    program_regs(1'b0, 32'hC0A8_0401, 32'hFFFF_FF00);
    pending_frames.push_back(slot_cmd(CMD_SET_ID, 4'd1, mac_pool[1], 1'b0));
    pending_frames.push_back(frame_up(mac_pool[1], 32'hC0A8_0420, 32'h0808_0808, 16'd40,
                                      16'd80, 32'd100));
    pending_frames.push_back(slot_cmd(CMD_SET_BLOCK, 4'd1, '0, 1'b0));
    pending_frames.push_back(frame_up(mac_pool[1], 32'hC0A8_0420, 32'h0808_0808, 16'd40,
                                      16'hFFFF, 32'hFFFF_FFFF));
    pending_frames.push_back(frame_up(mac_pool[1], 32'h0, 32'hC0A8_044D, 16'd40, 16'd90,
                                      32'd200));
    pending_frames.push_back(frame_up(mac_pool[1], 32'h0, 32'hEF01_0101, 16'd40, 16'd90,
                                      32'd201));
    pending_frames.push_back(frame_up(48'h0A0B_0C0D_0E0F, 32'h0, 32'h0808_0808, 16'd40,
                                      16'd90, 32'd202));
    pending_frames.push_back(frame_up(48'h0A0B_0C0D_0E0F, 32'h0, 32'hFFFF_FFFF, 16'd40,
                                      16'd90, 32'd203));
    queue_random(RANDOM_PER_PHASE);

    program_regs(1'b1, 32'h0A00_0001, 32'hFF00_0000);
    queue_random(RANDOM_PER_PHASE);
    program_regs(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_random(RANDOM_PER_PHASE);
    program_regs(1'b1, 32'h0000_0000, 32'h0000_0000);
    queue_random(RANDOM_PER_PHASE);
    program_regs(1'b0, 32'hAC10_0001, 32'hFFFF_F000);
    quiet_tail = 1'b1;
    queue_random(RANDOM_PER_PHASE);

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && predicted_verdicts.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
